>>> src/bcc_pkg.sv
// Shared types and constants for the block congruence covariance core.
package bcc_pkg;

  localparam int COEF_W     = 16;  // Q3.12 coefficient
  localparam int COEF_ROWS  = 4;   // coefficient rows held in configuration
  localparam int COEF_PER_ROW = 4; // coefficients packed in one row word
  localparam int SIGMA_W    = 32;  // Q15.16 covariance input
  localparam int SIGMA_NUM  = 4;   // sigma fields on the input channel
  localparam int TT_W       = 2 * COEF_W;       // Q7.24 coefficient product
  localparam int PROD_W     = TT_W + SIGMA_W;   // Q.40 full product
  localparam int POS_W      = 8;
  localparam int PLACE_W    = 10;
  localparam int COV_W      = 48;
  localparam int FRAC_DROP  = 24;  // Q.40 down to Q.16
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_PER_ROW * COEF_W;

  typedef logic [1:0]              row_idx_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
  typedef logic signed [SIGMA_W-1:0] sigma_t;
  typedef logic signed [COV_W-1:0]   cov_t;
  typedef logic [PLACE_W-1:0]        place_t;
  typedef logic [POS_W-1:0]          pos_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_COEF_ROW_ZERO  = 3'd0;
  localparam cfg_idx_t REG_COEF_ROW_ONE   = 3'd1;
  localparam cfg_idx_t REG_COEF_ROW_TWO   = 3'd2;
  localparam cfg_idx_t REG_COEF_ROW_THREE = 3'd3;

endpackage

>>> src/block_congruence_covariance_core.sv
// Top level of the block congruence covariance core: sequencer and result pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: a position (a,b)
//   inside the BLOCK_N by BLOCK_N blocks and the four process covariances at
//   that position. For every factor pair (i,j), i outer and j inner, the block
//   returns sum_k T(i,k)*T(j,k)*S_k(a,b) at row i*BLOCK_N+a, column j*BLOCK_N+b
//   on the output channel (out_valid_o / out_ready_i), last_of_item_o marking
//   the final result of an item.
//   Coefficient rows are written through the plain write port (cfg_we_i,
//   cfg_idx_i, cfg_wdata_i) while the block is idle; indexes past three are
//   dropped.
//   Throughput: one result per cycle while the receiver is ready. An item occupies
//   the pair sequencer for its EFF_M*EFF_M pairs; the next item is accepted in the
//   cycle its predecessor issues its last pair, so items run back to back. Each
//   result passes through the sequencer, coefficient product, sigma product, pair
//   sums and rounding into the output register.
//   Reset clears the coefficient rows to zero and empties sequencer and pipeline.
//   When the receiver stalls, the whole pipeline and the sequencer hold; nothing
//   is dropped or repeated, and the input side keeps accepting while the
//   sequencer is free.
module block_congruence_covariance_core #(
  parameter int M_FACTORS = 4,
  parameter int G_PROCS   = 4,
  parameter int BLOCK_N   = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  bcc_pkg::cfg_idx_t         cfg_idx_i,
  input  bcc_pkg::cfg_data_t        cfg_wdata_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                pos_row_i,
  input  logic [7:0]                pos_col_i,
  input  logic signed [31:0]        sigma_zero_i,
  input  logic signed [31:0]        sigma_one_i,
  input  logic signed [31:0]        sigma_two_i,
  input  logic signed [31:0]        sigma_three_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [9:0]                out_row_o,
  output logic [9:0]                out_col_o,
  output logic signed [47:0]        cov_value_o,
  output logic                      last_of_item_o
);
  import bcc_pkg::*;

  // Only four coefficient rows and four sigma fields exist
  localparam int EFF_M = (M_FACTORS < COEF_ROWS) ? M_FACTORS : COEF_ROWS;
  localparam int EFF_G = (G_PROCS < SIGMA_NUM) ? G_PROCS : SIGMA_NUM;
  localparam row_idx_t IDX_LAST = row_idx_t'(EFF_M - 1);
  // Placement wraps to the 10-bit field, so only BLOCK_N mod 1024 matters
  localparam place_t BLOCK_N_MOD = place_t'(BLOCK_N % (1 << PLACE_W));
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_DROP - 1);

  function automatic logic signed [COEF_W-1:0] coef_at(cfg_data_t row, row_idx_t k);
    coef_at = row[k*COEF_W +: COEF_W];
  endfunction

  // ---------------------------------------------------------------------------
  // Coefficient rows
  // ---------------------------------------------------------------------------
  cfg_data_t coef_q [COEF_ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < COEF_ROWS; r++) coef_q[r] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_ROW_ZERO:  coef_q[0] <= cfg_wdata_i;
        REG_COEF_ROW_ONE:   coef_q[1] <= cfg_wdata_i;
        REG_COEF_ROW_TWO:   coef_q[2] <= cfg_wdata_i;
        REG_COEF_ROW_THREE: coef_q[3] <= cfg_wdata_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: hold everything while a finished result waits
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  assign adv = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------------
  // Pair sequencer (stage 0): holds the current item and walks (i,j)
  // ---------------------------------------------------------------------------
  logic     busy_q, busy_d;
  row_idx_t i_q, i_d, j_q, j_d;
  pos_t     a_q, b_q;
  sigma_t   sig_q [SIGMA_NUM];
  logic     last_pair;
  logic     in_acc;

  assign last_pair  = (i_q == IDX_LAST) && (j_q == IDX_LAST);
  assign in_ready_o = !busy_q || (adv && last_pair);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    if (in_acc) begin
      busy_d = 1'b1;
      i_d    = '0;
      j_d    = '0;
    end else if (busy_q && adv) begin
      if (last_pair) begin
        busy_d = 1'b0;
      end else if (j_q == IDX_LAST) begin
        j_d = '0;
        i_d = i_q + row_idx_t'(1);
      end else begin
        j_d = j_q + row_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q      <= pos_row_i;
      b_q      <= pos_col_i;
      sig_q[0] <= sigma_zero_i;
      sig_q[1] <= sigma_one_i;
      sig_q[2] <= sigma_two_i;
      sig_q[3] <= sigma_three_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: coefficient products T(i,k)*T(j,k) and placement
  // ---------------------------------------------------------------------------
  logic                     v1_q;
  logic signed [TT_W-1:0]   tt1_q  [SIGMA_NUM];
  sigma_t                   sig1_q [SIGMA_NUM];
  place_t                   row1_q, col1_q;
  logic                     last1_q;

  // Stage 2: full products with sigma
  logic                     v2_q;
  logic signed [PROD_W-1:0] p2_q [SIGMA_NUM];
  place_t                   row2_q, col2_q;
  logic                     last2_q;

  // Stage 3: pair sums, rounding constant folded into the first
  logic                     v3_q;
  logic signed [PROD_W-1:0] h0_3_q, h1_3_q;
  place_t                   row3_q, col3_q;
  logic                     last3_q;

  // Stage 4: output register
  place_t                   out_row_q, out_col_q;
  cov_t                     cov_q;
  logic                     last_q;

  logic signed [PROD_W-1:0] pm [SIGMA_NUM];
  logic signed [PROD_W:0]   acc_sum;

  always_comb begin
    for (int k = 0; k < SIGMA_NUM; k++) begin
      pm[k] = (k < EFF_G) ? p2_q[k] : '0;  // drop processes past G_PROCS
    end
  end

  // Sum of four terms stays within 64 bits; one guard bit covers the pair sum
  assign acc_sum = {h0_3_q[PROD_W-1], h0_3_q} + {h1_3_q[PROD_W-1], h1_3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= busy_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < SIGMA_NUM; k++) begin
        tt1_q[k]  <= TT_W'(coef_at(coef_q[i_q], row_idx_t'(k)) *
                           coef_at(coef_q[j_q], row_idx_t'(k)));
        sig1_q[k] <= sig_q[k];
        p2_q[k]   <= PROD_W'(tt1_q[k] * sig1_q[k]);
      end
      row1_q  <= place_t'(place_t'(i_q) * BLOCK_N_MOD + place_t'(a_q));
      col1_q  <= place_t'(place_t'(j_q) * BLOCK_N_MOD + place_t'(b_q));
      last1_q <= last_pair;

      row2_q  <= row1_q;
      col2_q  <= col1_q;
      last2_q <= last1_q;

      h0_3_q  <= pm[0] + pm[1] + ROUND_HALF;
      h1_3_q  <= pm[2] + pm[3];
      row3_q  <= row2_q;
      col3_q  <= col2_q;
      last3_q <= last2_q;

      // Floor of the shifted sum rounds half up; the 41-bit result always fits
      // the 48-bit field, so sign extension suffices
      cov_q     <= COV_W'($signed(acc_sum[PROD_W:FRAC_DROP]));
      out_row_q <= row3_q;
      out_col_q <= col3_q;
      last_q    <= last3_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign cov_value_o    = cov_q;
  assign last_of_item_o = last_q;

endmodule

>>> src/bcc_checker.sv
// Port-level checker for the block congruence covariance core, with its bind.
module bcc_checker #(
  parameter int M_FACTORS = 4
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [9:0]         out_row_o,
  input logic [9:0]         out_col_o,
  input bcc_pkg::cov_t      cov_value_o,
  input logic               last_of_item_o
);
  import bcc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cov_value_o) && $stable(out_row_o) &&
                                    $stable(out_col_o) && $stable(last_of_item_o))
    else $error("stalled result changed");

  // With more than one factor an accepted item keeps the sequencer busy, so the input is not ready straight after it
  a_seq_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o || (M_FACTORS < 2))
    else $error("item taken while the previous one is still being sequenced");

  // Leaving reset the output side is empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present straight out of reset");

endmodule

bind block_congruence_covariance_core bcc_checker #(.M_FACTORS(M_FACTORS)) u_bcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_row_o      (out_row_o),
  .out_col_o      (out_col_o),
  .cov_value_o    (cov_value_o),
  .last_of_item_o (last_of_item_o)
);
